// ----- rtl/mcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpf_pkg
// Shared types and constants for the multi-channel pipe FIFO.
// ----------------------------------------------------------------------------
package mcpf_pkg;

	localparam int NUM_SLOTS  = 32;
	localparam int SLOT_W     = 6;             // handle width, 0 means no slot
	localparam int IDX_W      = 5;             // slot index 0..NUM_SLOTS-1
	localparam int RING_AW    = 12;            // ring of 4096 entries
	localparam int RING_WORDS = NUM_SLOTS * (1 << RING_AW);

	typedef enum logic [2:0] {
		FN_OPEN    = 3'd0,
		FN_WRITE   = 3'd1,
		FN_READ    = 3'd2,
		FN_PENDING = 3'd3,
		FN_CLOSE   = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BADH      = 2'd1,
		ST_EMPTYFULL = 2'd2,
		ST_NOSLOT    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_OPEN2,
		S_WPEER,
		S_RDATA
	} state_t;

	typedef struct packed {
		func_t             func;
		logic [SLOT_W-1:0] handle;
		logic [7:0]        data_in;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [7:0]        data_out;
		logic [11:0]       count;
		logic [SLOT_W-1:0] first_handle;
		logic [SLOT_W-1:0] second_handle;
	} result_t;

	typedef struct packed {
		logic    load;
		logic    look;
		logic    open_pair;
		logic    write_byte;
		logic    read_issue;
		logic    close_slot;
		logic    finish;
		status_t fin_status;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  hdl_ok;
		logic  peer_ok;
		logic  full;
		logic  empty;
		logic  pair_free;
	} dp_stat_t;

endpackage

// ----- rtl/mcpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcpf_ctrl
// Request sequencer: steps each request through lookup, peer check,
// ring access and result.
// ----------------------------------------------------------------------------
module mcpf_ctrl import mcpf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_LOOK;
			end
			S_LOOK: begin
				unique case (stat.func)
					FN_OPEN:  state_d = S_OPEN2;
					FN_WRITE: state_d = stat.hdl_ok ? S_WPEER : S_IDLE;
					FN_READ:  state_d = (stat.hdl_ok && !stat.empty) ? S_RDATA : S_IDLE;
					default:  state_d = S_IDLE;
				endcase
			end
			S_OPEN2, S_WPEER, S_RDATA: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.fin_status = ST_OK;
		busy           = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				unique case (stat.func)
					FN_OPEN: ;
					FN_WRITE: begin
						if (!stat.hdl_ok) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_BADH;
						end
					end
					FN_READ: begin
						if (!stat.hdl_ok) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_BADH;
						end else if (stat.empty) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_EMPTYFULL;
						end else begin
							cmd.read_issue = 1'b1;
						end
					end
					FN_PENDING: begin
						cmd.finish     = 1'b1;
						cmd.fin_status = stat.hdl_ok ? ST_OK : ST_BADH;
					end
					FN_CLOSE: begin
						cmd.finish     = 1'b1;
						cmd.fin_status = stat.hdl_ok ? ST_OK : ST_BADH;
						cmd.close_slot = stat.hdl_ok;
					end
					default: begin
						cmd.finish     = 1'b1;
						cmd.fin_status = ST_BADH;
					end
				endcase
			end
			S_OPEN2: begin
				cmd.finish     = 1'b1;
				cmd.open_pair  = stat.pair_free;
				cmd.fin_status = stat.pair_free ? ST_OK : ST_NOSLOT;
			end
			S_WPEER: begin
				cmd.finish = 1'b1;
				if (stat.peer_ok && !stat.full) begin
					cmd.write_byte = 1'b1;
				end else begin
					cmd.fin_status = ST_EMPTYFULL;
				end
			end
			S_RDATA: begin
				cmd.finish = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/mcpf_dp.sv -----
// ----------------------------------------------------------------------------
// mcpf_dp
// Slot table, ring pointers, byte ring memory and result register.
// ----------------------------------------------------------------------------
module mcpf_dp import mcpf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     done,
	output result_t  result
);

	req_t               req_q;
	logic [NUM_SLOTS-1:0] in_use_q;
	logic [SLOT_W-1:0]  peer_q [NUM_SLOTS];
	logic [RING_AW-1:0] head_q [NUM_SLOTS];
	logic [RING_AW-1:0] tail_q [NUM_SLOTS];
	logic [SLOT_W-1:0]  lpeer_q;
	logic [IDX_W-1:0]   a_idx_q;
	logic               a_ok_q;
	logic [7:0]         rd_data_q;
	logic [7:0]         ring_mem [RING_WORDS];
	result_t            result_q;
	logic               done_q;

	logic [IDX_W-1:0]     h_idx, p_idx, cp_idx, b_idx;
	logic [SLOT_W-1:0]    peer_rd;
	logic                 cp_ok, b_ok;
	logic [IDX_W:0]       fa, fb;
	logic [NUM_SLOTS-1:0] mask_b;
	logic [RING_AW-1:0]   held;

	// lowest clear bit, {found, index}
	function automatic logic [IDX_W:0] find_free(input logic [NUM_SLOTS-1:0] used);
		logic [IDX_W:0] r;
		r = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) r = {1'b1, IDX_W'(i)};
		end
		return r;
	endfunction

	assign h_idx   = IDX_W'(req_q.handle - SLOT_W'(1));
	assign p_idx   = IDX_W'(lpeer_q - SLOT_W'(1));
	assign peer_rd = peer_q[h_idx];
	assign cp_idx  = IDX_W'(peer_rd - SLOT_W'(1));
	assign cp_ok   = (peer_rd != '0) && (peer_rd <= SLOT_W'(NUM_SLOTS)) && in_use_q[cp_idx];
	assign held    = head_q[h_idx] - tail_q[h_idx];

	assign fa     = find_free(in_use_q);
	assign mask_b = in_use_q | (a_ok_q ? (NUM_SLOTS'(1) << a_idx_q) : '0);
	assign fb     = find_free(mask_b);
	assign b_ok   = fb[IDX_W];
	assign b_idx  = fb[IDX_W-1:0];

	always_comb begin
		stat.func      = req_q.func;
		stat.hdl_ok    = (req_q.handle != '0) && (req_q.handle <= SLOT_W'(NUM_SLOTS))
		                 && in_use_q[h_idx];
		stat.peer_ok   = (lpeer_q != '0) && (lpeer_q <= SLOT_W'(NUM_SLOTS)) && in_use_q[p_idx];
		stat.full      = (head_q[p_idx] + RING_AW'(1)) == tail_q[p_idx];
		stat.empty     = head_q[h_idx] == tail_q[h_idx];
		stat.pair_free = a_ok_q && b_ok;
	end

	// request capture and lookup registers
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.look) begin
			lpeer_q <= peer_rd;
			a_idx_q <= fa[IDX_W-1:0];
			a_ok_q  <= fa[IDX_W];
		end
	end

	// slot table and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				peer_q[i] <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (cmd.open_pair) begin
				in_use_q[a_idx_q] <= 1'b1;
				in_use_q[b_idx]   <= 1'b1;
				peer_q[a_idx_q]   <= SLOT_W'(b_idx) + SLOT_W'(1);
				peer_q[b_idx]     <= SLOT_W'(a_idx_q) + SLOT_W'(1);
				head_q[a_idx_q]   <= '0;
				tail_q[a_idx_q]   <= '0;
				head_q[b_idx]     <= '0;
				tail_q[b_idx]     <= '0;
			end
			if (cmd.write_byte) head_q[p_idx] <= head_q[p_idx] + RING_AW'(1);
			if (cmd.read_issue) tail_q[h_idx] <= tail_q[h_idx] + RING_AW'(1);
			if (cmd.close_slot) begin
				in_use_q[h_idx] <= 1'b0;
				peer_q[h_idx]   <= '0;
				head_q[h_idx]   <= '0;
				tail_q[h_idx]   <= '0;
				// the surviving end keeps its bytes but loses its peer
				if (cp_ok) peer_q[cp_idx] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_byte) ring_mem[{p_idx, head_q[p_idx]}] <= req_q.data_in;
	end

	always_ff @(posedge clk) begin
		if (cmd.read_issue) rd_data_q <= ring_mem[{h_idx, tail_q[h_idx]}];
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.status        <= cmd.fin_status;
			result_q.data_out      <= '0;
			result_q.count         <= '0;
			result_q.first_handle  <= '0;
			result_q.second_handle <= '0;
			if (cmd.fin_status == ST_OK) begin
				case (req_q.func)
					FN_READ:    result_q.data_out <= rd_data_q;
					FN_PENDING: result_q.count <= 12'(held);
					FN_OPEN: begin
						result_q.first_handle  <= SLOT_W'(a_idx_q) + SLOT_W'(1);
						result_q.second_handle <= SLOT_W'(b_idx) + SLOT_W'(1);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/multi_channel_pipe_fifo.sv -----
// ----------------------------------------------------------------------------
// multi_channel_pipe_fifo
// Pool of 32 paired channel slots, each with a 4096-entry byte ring.
// ----------------------------------------------------------------------------
// channel   handshake             payload
// request   start in, busy out    req    (func, handle, data_in)
// result    done strobe out       result (status, data_out, count, handles)
//
// A request goes through the lookup state and finishes there (pending, close,
// unknown func, bad handle, read of an empty ring) or goes on to a further
// state (open, write to a valid handle, read of a held byte) for the second
// free-slot search, the peer pointer check, or the registered ring read.
// The result strobe overlaps the next request's acceptance cycle.
// After reset all slots are free; ring contents are undefined until written.
// Results are never held off; done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module multi_channel_pipe_fifo import mcpf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  req_t    req,
	output logic    done,
	output result_t result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mcpf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	mcpf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.data_out == '0 && result.count == '0
		&& result.first_handle == '0 && result.second_handle == '0))
		else $error("failed request returned payload");

	a_open_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.first_handle != '0) |-> (result.second_handle > result.first_handle))
		else $error("open returned slots out of order");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multi_channel_pipe_fifo. A directed table covers
// bad handles, unknown functions, one-sided close and the empty ring. Random
// traffic follows, with bursts through live pairs, and midway the slot pool
// is run out. Every result is checked field by field against a directed
// row's fixed result or else against a behavioral model of the slot pool.
// ----------------------------------------------------------------------------
module tb;
	import mcpf_pkg::*;

	localparam int         RING_LEN    = 1 << RING_AW;
	localparam int         MAX_HANDLE  = (1 << SLOT_W) - 1;
	localparam logic [2:0] FN_BAD_LO   = 3'd5;
	localparam logic [2:0] FN_BAD_HI   = 3'd7;
	localparam int         RANDOM_REQS = 820;
	localparam int         IDLE_PCT    = 21;
	localparam int         MAX_PRINTS  = 100;

	typedef struct {
		logic [2:0]        f;
		logic [SLOT_W-1:0] h;
		logic [7:0]        d;
		bit                fixed;
		result_t           want;
	} plan_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	req_t    req;
	logic    done;
	result_t result;

	multi_channel_pipe_fifo dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// slot pool model
	bit               slot_open [1:NUM_SLOTS];
	bit [SLOT_W-1:0]  peer_of   [1:NUM_SLOTS];
	bit [RING_AW-1:0] wr_ptr    [1:NUM_SLOTS];
	bit [RING_AW-1:0] rd_ptr    [1:NUM_SLOTS];
	bit [7:0]         ring_mem  [1:NUM_SLOTS][0:RING_LEN-1];

	result_t   awaited_results [$];
	plan_row_t plan [$];
	int        err_count   = 0;
	int        idle_pct    = IDLE_PCT;
	int        reqs_issued = 0;
	result_t   want_r;

	function automatic result_t outcome(status_t st, int dout, int cnt, int r, int w);
		result_t o;
		o.status        = st;
		o.data_out      = 8'(dout);
		o.count         = 12'(cnt);
		o.first_handle  = SLOT_W'(r);
		o.second_handle = SLOT_W'(w);
		return o;
	endfunction

	function automatic plan_row_t plan_row(logic [2:0] f, int h, int d, bit fixed, result_t want);
		plan_row_t p;
		p.f     = f;
		p.h     = SLOT_W'(h);
		p.d     = 8'(d);
		p.fixed = fixed;
		p.want  = want;
		return p;
	endfunction

	function automatic bit [RING_AW-1:0] bytes_held(int s);
		return wr_ptr[s] - rd_ptr[s];
	endfunction

	function automatic bit handle_ok(logic [SLOT_W-1:0] h);
		return h != 0 && h <= NUM_SLOTS && slot_open[h];
	endfunction

	function automatic void clear_slot(int s);
		slot_open[s] = 1'b0;
		peer_of[s]   = '0;
		wr_ptr[s]    = '0;
		rd_ptr[s]    = '0;
	endfunction

	// applies one request to the model and returns its result
	function automatic result_t pipe_outcome(logic [2:0] f, logic [SLOT_W-1:0] h, logic [7:0] d);
		result_t o;
		int a;
		int b;
		int p;
		o        = '0;
		o.status = ST_BADH;
		a        = 0;
		b        = 0;
		if (f == FN_OPEN) begin
			for (int i = 1; i <= NUM_SLOTS; i++) begin
				if (!slot_open[i]) begin
					if (a == 0) a = i;
					else if (b == 0) b = i;
				end
			end
			if (b == 0) begin
				o.status = ST_NOSLOT;
			end else begin
				clear_slot(a);
				clear_slot(b);
				slot_open[a]    = 1'b1;
				slot_open[b]    = 1'b1;
				peer_of[a]      = SLOT_W'(b);
				peer_of[b]      = SLOT_W'(a);
				o.first_handle  = SLOT_W'(a);
				o.second_handle = SLOT_W'(b);
				o.status        = ST_OK;
			end
		end else if (f <= FN_CLOSE && handle_ok(h)) begin
			case (f)
			FN_WRITE: begin
				p = peer_of[h];
				if (p == 0 || !slot_open[p] || bytes_held(p) == RING_LEN - 1) begin
					o.status = ST_EMPTYFULL;
				end else begin
					ring_mem[p][wr_ptr[p]] = d;
					wr_ptr[p]++;
					o.status = ST_OK;
				end
			end
			FN_READ: begin
				if (bytes_held(h) == 0) begin
					o.status = ST_EMPTYFULL;
				end else begin
					o.data_out = ring_mem[h][rd_ptr[h]];
					rd_ptr[h]++;
					o.status = ST_OK;
				end
			end
			FN_PENDING: begin
				o.count  = bytes_held(h);
				o.status = ST_OK;
			end
			default: begin
				p = peer_of[h];
				clear_slot(h);
				if (p != 0 && slot_open[p]) peer_of[p] = '0;
				o.status = ST_OK;
			end
			endcase
		end
		return o;
	endfunction

	task automatic flag_mismatch(string what, int got, int exp_v);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, exp_v);
	endtask

	// results arrive in request order; each done pulse takes the oldest one
	always @(posedge clk) begin
		if (done) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("result with no request waiting", 1, 0);
			end else begin
				want_r = awaited_results.pop_front();
				if (result.status !== want_r.status)
					flag_mismatch("status", result.status, want_r.status);
				if (result.data_out !== want_r.data_out)
					flag_mismatch("data_out", result.data_out, want_r.data_out);
				if (result.count !== want_r.count)
					flag_mismatch("count", result.count, want_r.count);
				if (result.first_handle !== want_r.first_handle)
					flag_mismatch("first_handle", result.first_handle, want_r.first_handle);
				if (result.second_handle !== want_r.second_handle)
					flag_mismatch("second_handle", result.second_handle, want_r.second_handle);
			end
		end
	end

	// entered and left at a falling edge; start stays high for a following request
	task automatic send_request(logic [2:0] f, logic [SLOT_W-1:0] h, logic [7:0] d,
			bit fixed = 1'b0, result_t want = '0);
		result_t model_r;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		req.func    = func_t'(f);
		req.handle  = h;
		req.data_in = d;
		start       = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		model_r = pipe_outcome(f, h, d);
		awaited_results.push_back(fixed ? want : model_r);
		reqs_issued++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
	endtask

	function automatic logic [SLOT_W-1:0] pick_handle();
		int live [$];
		for (int s = 1; s <= NUM_SLOTS; s++)
			if (slot_open[s]) live.push_back(s);
		if (live.size() != 0 && $urandom_range(99) < 88)
			return SLOT_W'(live[$urandom_range(live.size() - 1)]);
		return SLOT_W'($urandom_range(MAX_HANDLE));
	endfunction

	// an open slot whose peer is still open, or 0
	function automatic logic [SLOT_W-1:0] pick_linked();
		int live [$];
		for (int s = 1; s <= NUM_SLOTS; s++)
			if (slot_open[s] && peer_of[s] != 0) live.push_back(s);
		if (live.size() == 0) return '0;
		return SLOT_W'(live[$urandom_range(live.size() - 1)]);
	endfunction

	task automatic exhaust_slots();
		for (int s = 1; s <= NUM_SLOTS; s++)
			if (slot_open[s]) send_request(FN_CLOSE, SLOT_W'(s), 8'h00);
		for (int k = 0; k < NUM_SLOTS / 2; k++)
			send_request(FN_OPEN, SLOT_W'($urandom_range(MAX_HANDLE)), 8'($urandom));
		send_request(FN_OPEN, '0, 8'h00, 1'b1, outcome(ST_NOSLOT, 0, 0, 0, 0));
		send_request(FN_CLOSE, SLOT_W'(5), 8'h00);
		// a single free slot is not enough for a pair
		send_request(FN_OPEN, '0, 8'h00, 1'b1, outcome(ST_NOSLOT, 0, 0, 0, 0));
		send_request(FN_CLOSE, SLOT_W'(6), 8'h00);
		send_request(FN_OPEN, '0, 8'h00);
		for (int s = 1; s <= NUM_SLOTS; s++)
			if (slot_open[s]) send_request(FN_CLOSE, SLOT_W'(s), 8'h00);
	endtask

	initial begin : stimulus
		int                sel;
		int                len;
		int                base;
		logic [SLOT_W-1:0] hw;
		logic [SLOT_W-1:0] hr;
		bit                pool_run = 1'b0;

		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		plan.push_back(plan_row(FN_READ,    0,  8'h00, 1, outcome(ST_BADH, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_PENDING, 1,  8'h00, 1, outcome(ST_BADH, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_BAD_LO,  1,  8'h3c, 1, outcome(ST_BADH, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_BAD_HI,  63, 8'hff, 1, outcome(ST_BADH, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_OPEN,    0,  8'h00, 1, outcome(ST_OK, 0, 0, 1, 2)));
		plan.push_back(plan_row(FN_WRITE,   1,  8'h00, 1, outcome(ST_OK, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_WRITE,   1,  8'hff, 1, outcome(ST_OK, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_WRITE,   2,  8'ha5, 1, outcome(ST_OK, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_PENDING, 2,  8'h00, 1, outcome(ST_OK, 0, 2, 0, 0)));
		plan.push_back(plan_row(FN_READ,    2,  8'h00, 1, outcome(ST_OK, 8'h00, 0, 0, 0)));
		plan.push_back(plan_row(FN_READ,    2,  8'h00, 1, outcome(ST_OK, 8'hff, 0, 0, 0)));
		plan.push_back(plan_row(FN_READ,    2,  8'h00, 1, outcome(ST_EMPTYFULL, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_WRITE,   33, 8'h55, 1, outcome(ST_BADH, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_CLOSE,   63, 8'h00, 1, outcome(ST_BADH, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_CLOSE,   0,  8'h00, 1, outcome(ST_BADH, 0, 0, 0, 0)));
		// one end closed: the other keeps its bytes but loses its peer
		plan.push_back(plan_row(FN_CLOSE,   2,  8'h00, 1, outcome(ST_OK, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_WRITE,   1,  8'h11, 1, outcome(ST_EMPTYFULL, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_PENDING, 1,  8'h00, 0, '0));
		plan.push_back(plan_row(FN_READ,    1,  8'h00, 1, outcome(ST_OK, 8'ha5, 0, 0, 0)));
		plan.push_back(plan_row(FN_PENDING, 2,  8'h00, 1, outcome(ST_BADH, 0, 0, 0, 0)));
		plan.push_back(plan_row(FN_OPEN,    0,  8'h00, 1, outcome(ST_OK, 0, 0, 2, 3)));
		plan.push_back(plan_row(FN_CLOSE,   1,  8'h00, 0, '0));
		plan.push_back(plan_row(FN_CLOSE,   2,  8'h00, 0, '0));
		plan.push_back(plan_row(FN_CLOSE,   3,  8'h00, 0, '0));
		foreach (plan[i])
			send_request(plan[i].f, plan[i].h, plan[i].d, plan[i].fixed, plan[i].want);
		wait_drained();

		base = reqs_issued;
		while (reqs_issued - base < RANDOM_REQS) begin
			idle_pct = (reqs_issued - base >= 250 && reqs_issued - base < 420) ? 0 : IDLE_PCT;
			if (!pool_run && reqs_issued - base >= 550) begin
				pool_run = 1'b1;
				exhaust_slots();
				// hold off until the pool is quiet
				wait_drained();
			end
			sel = $urandom_range(99);
			if (sel < 10) begin
				send_request(3'($urandom_range(7)), SLOT_W'($urandom_range(MAX_HANDLE)),
					8'($urandom));
			end else if (sel < 22) begin
				send_request(FN_OPEN, pick_handle(), 8'($urandom));
			end else if (sel < 47) begin
				send_request(FN_WRITE, pick_handle(), 8'($urandom));
			end else if (sel < 68) begin
				send_request(FN_READ, pick_handle(), 8'($urandom));
			end else if (sel < 78) begin
				send_request(FN_PENDING, pick_handle(), 8'($urandom));
			end else if (sel < 90) begin
				send_request(FN_CLOSE, pick_handle(), 8'($urandom));
			end else begin
				// a burst through a live pair, read back at the far end
				hw = pick_linked();
				if (hw != 0) begin
					hr  = peer_of[hw];
					len = $urandom_range(1, 12);
					for (int k = 0; k < len; k++)
						send_request(FN_WRITE, hw, 8'($urandom));
					if ($urandom_range(1)) send_request(FN_PENDING, hr, 8'h00);
					for (int k = 0; k < len; k++)
						send_request(FN_READ, hr, 8'($urandom));
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mcpf_pkg.sv
rtl/mcpf_ctrl.sv
rtl/mcpf_dp.sv
rtl/multi_channel_pipe_fifo.sv
bench/tb.sv
